>>> sv/ccirc_pkg.sv
package ccirc_pkg;

    // default coordinate width and field widths
    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_W        = 16;
    localparam int MODE_W         = 2;
    localparam int VALUE_W        = 27;

    // largest value the result field can hold
    localparam logic [VALUE_W-1:0] OUT_MAX = '1;

    // radius scale squared: 1000 * 1000
    localparam int RADIUS_SQ = 1000000;
    localparam int SCALE_W   = 21;

    // split multiplier: operand chunk width and stage count
    localparam int MUL_CHUNK = 24;
    localparam int MUL_LAT   = 5;

    // result selection codes
    typedef enum logic [MODE_W-1:0] {
        MODE_X = 2'd0,
        MODE_Y = 2'd1,
        MODE_R = 2'd2
    } t_mode;

endpackage

>>> sv/ccirc_if.sv
interface ccirc_in_if;
    import ccirc_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] first_x;
    logic [FIELD_W-1:0] first_y;
    logic [FIELD_W-1:0] second_x;
    logic [FIELD_W-1:0] second_y;
    logic [FIELD_W-1:0] third_x;
    logic [FIELD_W-1:0] third_y;
    logic [MODE_W-1:0]  mode;

    modport source (
        output valid, first_x, first_y, second_x, second_y, third_x, third_y, mode,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, second_x, second_y, third_x, third_y, mode,
        output ready
    );
endinterface

interface ccirc_out_if;
    import ccirc_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, value, input ready);
    modport sink (input valid, value, output ready);
endinterface

>>> sv/ccirc_mul.sv
module ccirc_mul #(
    parameter int WA = 8,
    parameter int WB = 8
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);
    import ccirc_pkg::*;

    localparam int K  = MUL_CHUNK;
    localparam int NA = (WA + K - 1) / K;
    localparam int NB = (WB + K - 1) / K;
    localparam int LA = NA * K;
    localparam int LB = NB * K;
    localparam int WW = (NB + 1) * K;
    localparam int WT = LA + LB;

    logic [WA-1:0]      mag_a;
    logic [WB-1:0]      mag_b;
    logic [LA-1:0]      r_ma;
    logic [LB-1:0]      r_mb;
    logic [3:0]         r_sg;
    logic [2*K-1:0]     r_pp [NA][NB];
    logic [WW-1:0]      n_row [NA];
    logic [WW-1:0]      r_row [NA];
    logic [WT-1:0]      n_sum;
    logic [WT-1:0]      r_sum;
    logic [WA+WB-1:0]   mag_p;
    logic signed [WA+WB-1:0] r_p;

    // magnitudes of the signed operands
    assign mag_a = i_a[WA-1] ? WA'(-i_a) : WA'(i_a);
    assign mag_b = i_b[WB-1] ? WB'(-i_b) : WB'(i_b);

    // row sums of the partial products
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (WW'(r_pp[i][j]) << (j * K));
            end
        end
    end

    // sum of the rows
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (WT'(r_row[i]) << (i * K));
        end
    end

    assign mag_p = r_sum[WA+WB-1:0];

    // five stages: magnitude, chunk products, rows, total, sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma <= LA'(mag_a);
            r_mb <= LB'(mag_b);
            r_sg <= {r_sg[2:0], i_a[WA-1] ^ i_b[WB-1]};
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= r_ma[i*K +: K] * r_mb[j*K +: K];
                end
            end
            r_row <= n_row;
            r_sum <= n_sum;
            r_p   <= r_sg[3] ? -mag_p : mag_p;
        end
    end

    assign o_p = r_p;

endmodule

>>> sv/ccirc_rootdiv.sv
module ccirc_rootdiv #(
    parameter int WM   = 40,
    parameter int WDEN = 16,
    parameter int QW   = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [WM-1:0]     i_rad,
    input  logic [WM/2-1:0]   i_num,
    input  logic [WDEN-1:0]   i_den,
    input  logic              i_root,
    output logic [QW-1:0]     o_quo
);
    localparam int WR  = WM / 2;
    localparam int WRM = WR + 2;
    localparam int WX  = (WR > WDEN + QW) ? WR : WDEN + QW;

    // square root stages, one result bit each
    logic [WRM-1:0]  r_rem [WR];
    logic [WR-1:0]   r_rt  [WR];
    logic [WM-1:0]   r_rad [WR];
    logic [WR-1:0]   r_num [WR];
    logic [WDEN-1:0] r_den [WR];
    logic [WR-1:0]   r_sel;

    // dividend select stage
    logic [WX-1:0]   r_n;
    logic [WDEN-1:0] r_d;

    // restoring divide stages, one quotient bit each
    logic [WX-1:0]   r_r  [QW];
    logic [QW-1:0]   r_q  [QW];
    logic [WDEN-1:0] r_dd [QW];

    for (genvar s = 0; s < WR; s++) begin : g_sq
        logic [WRM-1:0]  rem_in;
        logic [WRM-1:0]  rem2;
        logic [WRM-1:0]  trial;
        logic [WR-1:0]   rt_in;
        logic [WM-1:0]   rad_in;
        logic [WR-1:0]   num_in;
        logic [WDEN-1:0] den_in;
        logic            sel_in;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign rt_in  = '0;
            assign rad_in = i_rad;
            assign num_in = i_num;
            assign den_in = i_den;
            assign sel_in = i_root;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign rt_in  = r_rt[s-1];
            assign rad_in = r_rad[s-1];
            assign num_in = r_num[s-1];
            assign den_in = r_den[s-1];
            assign sel_in = r_sel[s-1];
        end

        // bring down two radicand bits and try root*4+1
        assign rem2  = {rem_in[WR-1:0], rad_in[WM-1 -: 2]};
        assign trial = {rt_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem2 >= trial) begin
                    r_rem[s] <= rem2 - trial;
                    r_rt[s]  <= {rt_in[WR-2:0], 1'b1};
                end else begin
                    r_rem[s] <= rem2;
                    r_rt[s]  <= {rt_in[WR-2:0], 1'b0};
                end
                r_rad[s] <= rad_in << 2;
                r_num[s] <= num_in;
                r_den[s] <= den_in;
                r_sel[s] <= sel_in;
            end
        end
    end

    // root for the radius, centre numerator otherwise
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= r_sel[WR-1] ? WX'(r_rt[WR-1]) : WX'(r_num[WR-1]);
            r_d <= r_den[WR-1];
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_dv
        localparam int SH = QW - 1 - j;
        logic [WX-1:0]   rr_in;
        logic [QW-1:0]   q_in;
        logic [WDEN-1:0] d_in;
        logic [WX-1:0]   trial;
        logic            ge;

        if (j == 0) begin : g_first
            assign rr_in = r_n;
            assign q_in  = '0;
            assign d_in  = r_d;
        end else begin : g_next
            assign rr_in = r_r[j-1];
            assign q_in  = r_q[j-1];
            assign d_in  = r_dd[j-1];
        end

        // compare against the shifted divisor
        assign trial = WX'(d_in) << SH;
        assign ge    = (rr_in >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[j]  <= ge ? rr_in - trial : rr_in;
                r_q[j]  <= {q_in[QW-2:0], ge};
                r_dd[j] <= d_in;
            end
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

>>> sv/circumcircle_three_points_unit.sv
// Circumcircle of three points, fully pipelined.
// Input channel i_in carries one triangle (three points of unsigned
// coordinates, low COORD_BITS bits used) and a mode per item; output
// channel o_out returns one value per item, in order: centre x (mode 0),
// centre y (mode 1), or floor(1000 * radius) (mode 2), each 0 when the
// points are collinear, the mode is undefined, or the centre lies outside
// the triangle.
// Throughput: one item per clock while no item waits in the skid stage.
// Most of the pipeline depth is the square root (one bit per stage)
// and the restoring divider (one quotient bit per stage).
// Reset clears every valid bit; the pipeline is empty afterwards.
// When o_out.ready is low the result waits in the output register and the
// pipeline keeps moving into a one-item skid stage; once that is taken the
// whole pipeline holds and i_in.ready drops, nothing is lost or repeated.
module circumcircle_three_points_unit #(
    parameter int COORD_BITS = ccirc_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ccirc_in_if.sink    i_in,
    ccirc_out_if.source o_out
);
    import ccirc_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int WD    = C + 1;
    localparam int WG    = 2 * C + 4;
    localparam int WP    = 2 * WD;
    localparam int WN    = 3 * C + 4;
    localparam int WGA   = WG + WD;
    localparam int WU    = 3 * C + 6;
    localparam int WS    = WU + WD + 1;
    localparam int WSQ   = 2 * WN;
    localparam int WM    = WSQ + 20;
    localparam int WR    = WM / 2;
    localparam int QW    = C + 12;
    localparam int QX    = (QW > VALUE_W) ? QW : VALUE_W;
    localparam int LATRD = WR + 1 + QW;
    localparam int TOT   = 22 + LATRD;
    localparam int W1    = WG + 6 * WD + MODE_W;
    localparam int W2    = WG + 2 * WU + MODE_W;
    localparam int W3    = 1 + W2;

    logic en;
    logic accept;

    // pipeline valid bits, one per stage
    logic [TOT-1:0] r_vld;

    // stage 1: differences
    logic signed [WD-1:0] r1_a, r1_b, r1_c, r1_d, r1_e, r1_f;
    logic [C-1:0]         r1_ax, r1_ay;
    logic [MODE_W-1:0]    r1_mode;
    logic [C-1:0]         ax, ay, bx, by, cx, cy;

    // stage 2: small products
    logic signed [WP-1:0] r2_ad, r2_bc, r2_aa, r2_bb, r2_cc, r2_dd;
    logic signed [WD-1:0] r2_a, r2_b, r2_c, r2_d, r2_e, r2_f;
    logic [C-1:0]         r2_ax, r2_ay;
    logic [MODE_W-1:0]    r2_mode;

    // stage 3: g, p, q
    logic signed [WG-1:0] r3_g;
    logic signed [WG-1:0] gd_w;
    logic signed [WP-1:0] r3_p, r3_q;
    logic signed [WD-1:0] r3_a, r3_b, r3_c, r3_d, r3_e, r3_f;
    logic [C-1:0]         r3_ax, r3_ay;
    logic [MODE_W-1:0]    r3_mode;

    // second product level, ready at stage 8
    logic signed [WD+WP-1:0] m_dp, m_bq, m_aq, m_cp;
    logic signed [WGA-1:0]   m_ga, m_gb, m_gc, m_gd, m_xg, m_yg;
    logic [W1-1:0]           r_dl1 [MUL_LAT];
    logic signed [WG-1:0]    d1_g;
    logic signed [WD-1:0]    d1_a, d1_b, d1_c, d1_d, d1_e, d1_f;
    logic [MODE_W-1:0]       d1_mode;

    // stage 9: centre numerators
    logic signed [WN-1:0]  r9_nx, r9_ny;
    logic signed [WGA-1:0] r9_ga, r9_gb, r9_gc, r9_gd, r9_xg, r9_yg;
    logic signed [WG-1:0]  r9_g;
    logic signed [WD-1:0]  r9_a, r9_b, r9_c, r9_d, r9_e, r9_f;
    logic [MODE_W-1:0]     r9_mode;

    // stage 10: edge terms and offset numerators
    logic signed [WU-1:0]  r10_nx, r10_ny, r10_u1, r10_u2, r10_u3, r10_u4;
    logic signed [WU-1:0]  r10_mx, r10_my;
    logic signed [WG-1:0]  r10_g;
    logic signed [WD-1:0]  r10_a, r10_b, r10_c, r10_d, r10_e, r10_f;
    logic [MODE_W-1:0]     r10_mode;

    // third product level, ready at stage 15
    logic signed [WU+WD-1:0] m_s1a, m_s1b, m_s2a, m_s2b, m_s3a, m_s3b;
    logic signed [2*WU-1:0]  m_nn, m_yy;
    logic [W2-1:0]           r_dl2 [MUL_LAT];
    logic signed [WG-1:0]    d2_g;
    logic signed [WU-1:0]    d2_mx, d2_my;
    logic [MODE_W-1:0]       d2_mode;

    // stage 16: cross products and squared distance
    logic signed [WS-1:0]  r16_s1, r16_s2, r16_s3;
    logic signed [WSQ-1:0] r16_sq;
    logic signed [WG-1:0]  r16_g;
    logic signed [WU-1:0]  r16_mx, r16_my;
    logic [MODE_W-1:0]     r16_mode;
    logic                  n1, n2, n3, p1, p2, p3, mode_ok, ok16;

    // scaled squared radius, ready at stage 21
    logic signed [WSQ+SCALE_W-1:0] m_rad;
    logic [W3-1:0]                 r_dl3 [MUL_LAT];
    logic                          d3_ok;
    logic signed [WG-1:0]          d3_g;
    logic signed [WU-1:0]          d3_mx, d3_my;
    logic [MODE_W-1:0]             d3_mode;

    // stage 22: divider operands
    logic signed [WU:0]   mm_e, sm;
    logic                 root;
    logic [WM-1:0]        r22_rad;
    logic [WR-1:0]        r22_num;
    logic [WG-1:0]        r22_den;
    logic                 r22_root;
    logic                 r22_keep;

    // root and divide results
    logic [QW-1:0]        quo;
    logic [LATRD-1:0]     r_keep;
    logic [QX-1:0]        qx;
    logic [VALUE_W-1:0]   res;

    // output register and skid stage
    logic                 r_ov, r_sv;
    logic [VALUE_W-1:0]   r_od, r_sd;
    logic                 take;
    logic                 pv;

    // the pipeline moves unless the skid stage is holding an item
    assign en     = !r_sv;
    assign accept = i_in.valid && en;
    assign i_in.ready = en;

    assign ax = C'(i_in.first_x);
    assign ay = C'(i_in.first_y);
    assign bx = C'(i_in.second_x);
    assign by = C'(i_in.second_y);
    assign cx = C'(i_in.third_x);
    assign cy = C'(i_in.third_y);

    assign gd_w = WG'(r2_ad) - WG'(r2_bc);

    // second product level
    ccirc_mul #(.WA(WD), .WB(WP)) u_dp (.i_clk, .i_en(en), .i_a(r3_d), .i_b(r3_p), .o_p(m_dp));
    ccirc_mul #(.WA(WD), .WB(WP)) u_bq (.i_clk, .i_en(en), .i_a(r3_b), .i_b(r3_q), .o_p(m_bq));
    ccirc_mul #(.WA(WD), .WB(WP)) u_aq (.i_clk, .i_en(en), .i_a(r3_a), .i_b(r3_q), .o_p(m_aq));
    ccirc_mul #(.WA(WD), .WB(WP)) u_cp (.i_clk, .i_en(en), .i_a(r3_c), .i_b(r3_p), .o_p(m_cp));
    ccirc_mul #(.WA(WG), .WB(WD)) u_ga (.i_clk, .i_en(en), .i_a(r3_g), .i_b(r3_a), .o_p(m_ga));
    ccirc_mul #(.WA(WG), .WB(WD)) u_gb (.i_clk, .i_en(en), .i_a(r3_g), .i_b(r3_b), .o_p(m_gb));
    ccirc_mul #(.WA(WG), .WB(WD)) u_gc (.i_clk, .i_en(en), .i_a(r3_g), .i_b(r3_c), .o_p(m_gc));
    ccirc_mul #(.WA(WG), .WB(WD)) u_gd (.i_clk, .i_en(en), .i_a(r3_g), .i_b(r3_d), .o_p(m_gd));
    ccirc_mul #(.WA(WG), .WB(WD)) u_xg (
        .i_clk, .i_en(en), .i_a(r3_g), .i_b(signed'({1'b0, r3_ax})), .o_p(m_xg)
    );
    ccirc_mul #(.WA(WG), .WB(WD)) u_yg (
        .i_clk, .i_en(en), .i_a(r3_g), .i_b(signed'({1'b0, r3_ay})), .o_p(m_yg)
    );

    assign {d1_g, d1_a, d1_b, d1_c, d1_d, d1_e, d1_f, d1_mode} = r_dl1[MUL_LAT-1];

    // third product level
    ccirc_mul #(.WA(WU), .WB(WD)) u_s1a (
        .i_clk, .i_en(en), .i_a(r10_nx), .i_b(r10_b), .o_p(m_s1a)
    );
    ccirc_mul #(.WA(WU), .WB(WD)) u_s1b (
        .i_clk, .i_en(en), .i_a(r10_ny), .i_b(r10_a), .o_p(m_s1b)
    );
    ccirc_mul #(.WA(WU), .WB(WD)) u_s2a (
        .i_clk, .i_en(en), .i_a(r10_u1), .i_b(r10_e), .o_p(m_s2a)
    );
    ccirc_mul #(.WA(WU), .WB(WD)) u_s2b (
        .i_clk, .i_en(en), .i_a(r10_u2), .i_b(r10_f), .o_p(m_s2b)
    );
    ccirc_mul #(.WA(WU), .WB(WD)) u_s3a (
        .i_clk, .i_en(en), .i_a(r10_u3), .i_b(r10_c), .o_p(m_s3a)
    );
    ccirc_mul #(.WA(WU), .WB(WD)) u_s3b (
        .i_clk, .i_en(en), .i_a(r10_u4), .i_b(r10_d), .o_p(m_s3b)
    );
    ccirc_mul #(.WA(WU), .WB(WU)) u_nn (
        .i_clk, .i_en(en), .i_a(r10_nx), .i_b(r10_nx), .o_p(m_nn)
    );
    ccirc_mul #(.WA(WU), .WB(WU)) u_yy (
        .i_clk, .i_en(en), .i_a(r10_ny), .i_b(r10_ny), .o_p(m_yy)
    );

    assign {d2_g, d2_mx, d2_my, d2_mode} = r_dl2[MUL_LAT-1];

    // centre inside or on the triangle: all edge signs agree
    assign n1 = r16_s1[WS-1];
    assign n2 = r16_s2[WS-1];
    assign n3 = r16_s3[WS-1];
    assign p1 = n1 || (r16_s1 == '0);
    assign p2 = n2 || (r16_s2 == '0);
    assign p3 = n3 || (r16_s3 == '0);
    assign mode_ok = (r16_mode == MODE_X) || (r16_mode == MODE_Y) || (r16_mode == MODE_R);
    assign ok16 = mode_ok && (r16_g != '0) && ((!n1 && !n2 && !n3) || (p1 && p2 && p3));

    // squared radius numerator (nx^2 + ny^2) times one million
    ccirc_mul #(.WA(WSQ), .WB(SCALE_W)) u_rad (
        .i_clk, .i_en(en), .i_a(r16_sq), .i_b(signed'(SCALE_W'(RADIUS_SQ))), .o_p(m_rad)
    );

    assign {d3_ok, d3_g, d3_mx, d3_my, d3_mode} = r_dl3[MUL_LAT-1];

    // centre numerator with the sign of g folded in
    assign mm_e = (d3_mode == MODE_Y) ? (WU+1)'(d3_my) : (WU+1)'(d3_mx);
    assign sm   = d3_g[WG-1] ? -mm_e : mm_e;
    assign root = (d3_mode == MODE_R);

    ccirc_rootdiv #(.WM(WM), .WDEN(WG), .QW(QW)) u_rootdiv (
        .i_clk,
        .i_en   (en),
        .i_rad  (r22_rad),
        .i_num  (r22_num),
        .i_den  (r22_den),
        .i_root (r22_root),
        .o_quo  (quo)
    );

    // clamp to the result field, zero for a rejected circle
    assign qx  = QX'(quo);
    assign res = !r_keep[LATRD-1] ? '0 :
                 (qx > QX'(OUT_MAX)) ? OUT_MAX : qx[VALUE_W-1:0];
    assign pv  = r_vld[TOT-1];

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a    <= signed'(WD'(bx)) - signed'(WD'(ax));
            r1_b    <= signed'(WD'(by)) - signed'(WD'(ay));
            r1_c    <= signed'(WD'(cx)) - signed'(WD'(ax));
            r1_d    <= signed'(WD'(cy)) - signed'(WD'(ay));
            r1_e    <= signed'(WD'(cy)) - signed'(WD'(by));
            r1_f    <= signed'(WD'(cx)) - signed'(WD'(bx));
            r1_ax   <= ax;
            r1_ay   <= ay;
            r1_mode <= i_in.mode;

            r2_ad <= r1_a * r1_d;
            r2_bc <= r1_b * r1_c;
            r2_aa <= r1_a * r1_a;
            r2_bb <= r1_b * r1_b;
            r2_cc <= r1_c * r1_c;
            r2_dd <= r1_d * r1_d;
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_c  <= r1_c;
            r2_d  <= r1_d;
            r2_e  <= r1_e;
            r2_f  <= r1_f;
            r2_ax <= r1_ax;
            r2_ay <= r1_ay;
            r2_mode <= r1_mode;

            r3_g  <= gd_w <<< 1;
            r3_p  <= r2_aa + r2_bb;
            r3_q  <= r2_cc + r2_dd;
            r3_a  <= r2_a;
            r3_b  <= r2_b;
            r3_c  <= r2_c;
            r3_d  <= r2_d;
            r3_e  <= r2_e;
            r3_f  <= r2_f;
            r3_ax <= r2_ax;
            r3_ay <= r2_ay;
            r3_mode <= r2_mode;

            r_dl1[0] <= {r3_g, r3_a, r3_b, r3_c, r3_d, r3_e, r3_f, r3_mode};
            for (int i = 1; i < MUL_LAT; i++) begin
                r_dl1[i] <= r_dl1[i-1];
            end

            r9_nx <= WN'(m_dp) - WN'(m_bq);
            r9_ny <= WN'(m_aq) - WN'(m_cp);
            r9_ga <= m_ga;
            r9_gb <= m_gb;
            r9_gc <= m_gc;
            r9_gd <= m_gd;
            r9_xg <= m_xg;
            r9_yg <= m_yg;
            r9_g  <= d1_g;
            r9_a  <= d1_a;
            r9_b  <= d1_b;
            r9_c  <= d1_c;
            r9_d  <= d1_d;
            r9_e  <= d1_e;
            r9_f  <= d1_f;
            r9_mode <= d1_mode;

            r10_nx <= WU'(r9_nx);
            r10_ny <= WU'(r9_ny);
            r10_u1 <= WU'(r9_nx) - WU'(r9_ga);
            r10_u2 <= WU'(r9_ny) - WU'(r9_gb);
            r10_u3 <= WU'(r9_ny) - WU'(r9_gd);
            r10_u4 <= WU'(r9_nx) - WU'(r9_gc);
            r10_mx <= WU'(r9_xg) + WU'(r9_nx);
            r10_my <= WU'(r9_yg) + WU'(r9_ny);
            r10_g  <= r9_g;
            r10_a  <= r9_a;
            r10_b  <= r9_b;
            r10_c  <= r9_c;
            r10_d  <= r9_d;
            r10_e  <= r9_e;
            r10_f  <= r9_f;
            r10_mode <= r9_mode;

            r_dl2[0] <= {r10_g, r10_mx, r10_my, r10_mode};
            for (int i = 1; i < MUL_LAT; i++) begin
                r_dl2[i] <= r_dl2[i-1];
            end

            r16_s1 <= WS'(m_s1a) - WS'(m_s1b);
            r16_s2 <= WS'(m_s2a) - WS'(m_s2b);
            r16_s3 <= WS'(m_s3a) - WS'(m_s3b);
            r16_sq <= WSQ'(m_nn) + WSQ'(m_yy);
            r16_g  <= d2_g;
            r16_mx <= d2_mx;
            r16_my <= d2_my;
            r16_mode <= d2_mode;

            r_dl3[0] <= {ok16, r16_g, r16_mx, r16_my, r16_mode};
            for (int i = 1; i < MUL_LAT; i++) begin
                r_dl3[i] <= r_dl3[i-1];
            end

            r22_rad  <= m_rad[WM-1:0];
            r22_num  <= WR'(sm[WU-1:0]);
            r22_den  <= d3_g[WG-1] ? WG'(-d3_g) : WG'(d3_g);
            r22_root <= root;
            r22_keep <= d3_ok && (root || !sm[WU]);

            r_keep <= {r_keep[LATRD-2:0], r22_keep};
        end
    end

    // valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOT-2:0], accept};
        end
    end

    // output register with one skid stage behind it
    assign take = r_ov && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (take) begin
                r_od <= r_sd;
                r_sv <= 1'b0;
            end
        end else if (!r_ov || take) begin
            r_ov <= pv;
            r_od <= res;
        end else if (pv) begin
            r_sv <= 1'b1;
            r_sd <= res;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.value = r_od;

endmodule
